FILE: sv/fbfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    localparam int MAX_BLOCKS = 65536;
    localparam int ALIGN      = 16;
    localparam int MIN_BLOCK  = 8;

    localparam int HANDLE_W   = 16;
    localparam int LINK_DEPTH = 1 << HANDLE_W;
    localparam int CARVE_W    = $clog2(MAX_BLOCKS + 1);
    localparam int BB_W       = 13;
    localparam int BPC_W      = 17;
    localparam int CHUNK_W    = 17;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 17;
    localparam int ALIGN_SH   = $clog2(ALIGN);
    localparam int SIZE_MAX   = (1 << BB_W) - 1;

    localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(64);
    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(8192);

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;

    localparam logic CFG_BLOCK_BYTES      = 1'b0;
    localparam logic CFG_BLOCKS_PER_CHUNK = 1'b1;

    typedef struct packed {
        logic                action;
        logic                handle_valid;
        logic [HANDLE_W-1:0] release_handle;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        logic [1:0]          status;
        logic [CNT_W-1:0]    alloc_total;
        logic [CNT_W-1:0]    free_total;
        logic [CHUNK_W-1:0]  chunk_total;
        logic [BB_W-1:0]     aligned_block_bytes;
    } t_rsp;

    typedef struct packed {
        logic [HANDLE_W-1:0] link;
        logic                last;
    } t_link;

    typedef struct packed {
        logic                we;
        logic [HANDLE_W-1:0] addr;
        t_link               wdata;
    } t_ram_req;

endpackage
`default_nettype wire

FILE: sv/fbfl_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_link_ram
// Single-port link memory: successor handle and list-end flag per handle.
// ----------------------------------------------------------------------------
module fbfl_link_ram
    import fbfl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_link         o_rdata
);

    t_link r_mem [LINK_DEPTH];
    t_link r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/fbfl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Free-list sequencer: push, pop and chunk carving over the link memory.
// ----------------------------------------------------------------------------
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_req              i_req,
    input  wire logic [BPC_W-1:0]  i_bpc,
    input  wire logic [BB_W-1:0]   i_aligned,
    input  wire logic              i_slot_free,
    input  wire t_link             i_rdata,
    output t_ram_req               o_ram,
    output logic                   o_idle,
    output logic                   o_done,
    output t_rsp                   o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_CARVE = 6'b000100,
        S_RD    = 6'b001000,
        S_POP   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state,   n_state;
    t_req                 r_req,     n_req;
    logic [HANDLE_W-1:0]  r_head,    n_head;
    logic                 r_empty,   n_empty;
    logic [CARVE_W-1:0]   r_carved,  n_carved;
    logic [CHUNK_W-1:0]   r_chunk,   n_chunk;
    logic [CNT_W-1:0]     r_alloc,   n_alloc;
    logic [CNT_W-1:0]     r_free,    n_free;
    logic [CARVE_W-1:0]   r_addr,    n_addr;
    logic [CARVE_W-1:0]   r_last,    n_last;
    logic [HANDLE_W-1:0]  r_granted, n_granted;
    logic [1:0]           r_status,  n_status;

    logic [BPC_W-1:0]     w_n;
    logic [CARVE_W:0]     w_need;
    logic [CARVE_W-1:0]   w_addr_inc;

    assign w_n        = (i_bpc == '0) ? BPC_W'(1) : i_bpc;
    assign w_need     = (CARVE_W+1)'(r_carved) + (CARVE_W+1)'(w_n);
    assign w_addr_inc = r_addr + CARVE_W'(1);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_head    = r_head;
        n_empty   = r_empty;
        n_carved  = r_carved;
        n_chunk   = r_chunk;
        n_alloc   = r_alloc;
        n_free    = r_free;
        n_addr    = r_addr;
        n_last    = r_last;
        n_granted = r_granted;
        n_status  = r_status;
        o_ram       = '0;
        o_ram.addr  = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_granted = '0;
                n_status  = ST_OK;
                if (r_req.action == ACT_RELEASE) begin
                    if (r_req.handle_valid) begin
                        o_ram.we    = 1'b1;
                        o_ram.addr  = r_req.release_handle;
                        o_ram.wdata = '{link: r_head, last: r_empty};
                        n_head      = r_req.release_handle;
                        n_empty     = 1'b0;
                        n_free      = r_free + CNT_W'(1);
                    end else begin
                        n_status = ST_NULL;
                    end
                    n_state = S_DONE;
                end else if (!r_empty) begin
                    n_state = S_POP;
                end else if (w_need > (CARVE_W+1)'(MAX_BLOCKS)) begin
                    n_status = ST_EXHAUST;
                    n_state  = S_DONE;
                end else begin
                    n_addr  = r_carved;
                    n_last  = CARVE_W'(w_need - (CARVE_W+1)'(1));
                    n_state = S_CARVE;
                end
            end
            S_CARVE: begin
                o_ram.we    = 1'b1;
                o_ram.addr  = r_addr[HANDLE_W-1:0];
                o_ram.wdata = '{link: r_head, last: r_empty};
                n_head      = r_addr[HANDLE_W-1:0];
                n_empty     = 1'b0;
                n_addr      = w_addr_inc;
                if (r_addr == r_last) begin
                    n_carved = w_addr_inc;
                    n_chunk  = r_chunk + CHUNK_W'(1);
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                n_state = S_POP;
            end
            S_POP: begin
                n_granted = r_head;
                n_head    = i_rdata.link;
                n_empty   = i_rdata.last;
                n_alloc   = r_alloc + CNT_W'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_empty  <= 1'b1;
            r_carved <= '0;
            r_chunk  <= '0;
            r_alloc  <= '0;
            r_free   <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_empty  <= n_empty;
            r_carved <= n_carved;
            r_chunk  <= n_chunk;
            r_alloc  <= n_alloc;
            r_free   <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_addr    <= n_addr;
        r_last    <= n_last;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE) && i_slot_free;

    always_comb begin
        o_rsp.granted_handle      = r_granted;
        o_rsp.status              = r_status;
        o_rsp.alloc_total         = r_alloc;
        o_rsp.free_total          = r_free;
        o_rsp.chunk_total         = r_chunk;
        o_rsp.aligned_block_bytes = i_aligned;
    end

    a_carve_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CARVE) |-> (r_addr <= r_last))
        else $error("carve address past chunk end");

    a_list_after_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !r_empty)
        else $error("list empty after carve");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_alloc == $past(r_alloc) + CNT_W'(1)))
        else $error("pop without allocation count");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status != ST_OK) |-> (r_granted == '0))
        else $error("handle granted on failed request");

    a_carved_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_carved <= CARVE_W'(MAX_BLOCKS))
        else $error("carved count beyond capacity");

endmodule
`default_nettype wire

FILE: sv/fixed_block_free_list_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Fixed-size block allocator keeping a LIFO free list of handles in a link
// memory, growing it chunk by chunk on demand.
// ----------------------------------------------------------------------------
// One request is taken at a time. A release, a null release or an exhausted
// allocate goes from the execute state to the done state, an allocate from a
// non-empty list goes through the pop state, and an allocate that grows the
// list carves max(blocks_per_chunk, 1) handles, the single write port of the
// link memory linking one new handle per cycle, then reads and pops the head.
// A new request is accepted once the previous result has moved into the output
// register. No clearing pass follows reset; the block is ready right after it.
module fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire t_req             i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output t_rsp                  o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    logic [BB_W-1:0]  r_block_bytes;
    logic [BPC_W-1:0] r_bpc;
    logic             r_out_valid;
    t_rsp             r_rsp;

    logic [BB_W-1:0]  w_min;
    logic [BB_W:0]    w_sum;
    logic [BB_W:0]    w_round;
    logic [BB_W-1:0]  w_aligned;
    logic             w_slot_free;
    logic             w_idle;
    logic             w_done;
    t_rsp             w_rsp;
    t_ram_req         w_ram;
    t_link            w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BB_RESET;
            r_bpc         <= BPC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_BYTES:      r_block_bytes <= i_cfg_wdata[BB_W-1:0];
                CFG_BLOCKS_PER_CHUNK: r_bpc         <= i_cfg_wdata[BPC_W-1:0];
                default:              r_bpc         <= r_bpc;
            endcase
        end
    end

    assign w_min     = (r_block_bytes < BB_W'(MIN_BLOCK)) ? BB_W'(MIN_BLOCK) : r_block_bytes;
    assign w_sum     = (BB_W+1)'(w_min) + (BB_W+1)'(ALIGN - 1);
    assign w_round   = (w_sum >> ALIGN_SH) << ALIGN_SH;
    assign w_aligned = (w_round > (BB_W+1)'(SIZE_MAX)) ? BB_W'(SIZE_MAX) : w_round[BB_W-1:0];

    assign w_slot_free = !r_out_valid || i_rsp_ready;

    fbfl_link_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram),
        .o_rdata (w_rdata)
    );

    fbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req_valid && o_req_ready),
        .i_req       (i_req),
        .i_bpc       (r_bpc),
        .i_aligned   (w_aligned),
        .i_slot_free (w_slot_free),
        .i_rdata     (w_rdata),
        .o_ram       (w_ram),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_rsp       (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_req_ready = w_idle;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule
`default_nettype wire
